// ----- hw/rtl/argb_alpha_blend_unit_assert.svh -----
// Assertion macros for the alpha blend unit.
// Needs aclk and aresetn in the scope of each use.
`ifndef ARGB_ALPHA_BLEND_UNIT_ASSERT_SVH
`define ARGB_ALPHA_BLEND_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ABU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ABU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/abu_pkg.sv -----
// Shared types and codes of the alpha blend pipeline.
// No dependencies.
package abu_pkg;

    // Alpha source selector codes
    localparam logic [1:0] CMD_PIXEL    = 2'd0;
    localparam logic [1:0] CMD_EXPLICIT = 2'd1;
    localparam logic [1:0] CMD_SCALED   = 2'd2;

    // How the result pixel is formed
    typedef enum logic [2:0] {
        KIND_BLEND = 3'd0,
        KIND_FULL  = 3'd1,
        KIND_SRC   = 3'd2,
        KIND_ZERO  = 3'd3,
        KIND_DST   = 3'd4
    } kind_t;

    // After alpha selection: effective alpha may exceed 255
    typedef struct packed {
        logic [8:0]  sa;
        logic [31:0] src;
        logic [31:0] dst;
    } alpha_req_t;

    // After classification and alpha products
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  sa8;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] dinv_prod;
        logic [15:0] sd_prod;
    } weight_req_t;

    // After normalisation by 255
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  sa8;
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  dmul;
        logic [7:0]  oa;
    } norm_req_t;

endpackage

// ----- hw/rtl/abu_alpha_stage.sv -----
// Stage 1: pick the effective source alpha.
// Depends on abu_pkg.
module abu_alpha_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic [31:0]        src_pixel,
    input  logic [31:0]        dst_pixel,
    input  logic [7:0]         explicit_alpha,
    input  logic [8:0]         alpha_scale,
    output logic               out_valid,
    input  logic               out_ready,
    output abu_pkg::alpha_req_t out_data
);
    import abu_pkg::*;

    logic       valid_reg, valid_next;
    alpha_req_t data_reg, data_next;
    logic [16:0] scaled;

    assign scaled = {9'b0, src_pixel[31:24]} * {8'b0, alpha_scale};

    always_comb begin
        data_next.src = src_pixel;
        data_next.dst = dst_pixel;
        case (cmd)
            CMD_PIXEL:    data_next.sa = {1'b0, src_pixel[31:24]};
            CMD_EXPLICIT: data_next.sa = {1'b0, explicit_alpha};
            CMD_SCALED:   data_next.sa = scaled[16:8];
            default:      data_next.sa = {1'b0, src_pixel[31:24]};
        endcase
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- hw/rtl/abu_weight_stage.sv -----
// Stage 2: classify the pixel pair and form the alpha products.
// Depends on abu_pkg.
module abu_weight_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  abu_pkg::alpha_req_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output abu_pkg::weight_req_t out_data
);
    import abu_pkg::*;

    logic        valid_reg, valid_next;
    weight_req_t data_reg, data_next;
    logic [7:0]  da;
    logic [7:0]  sa8;
    logic [7:0]  inv;

    assign da  = in_data.dst[31:24];
    assign sa8 = in_data.sa[7:0];
    assign inv = 8'd255 - sa8;

    always_comb begin
        data_next.sa8       = sa8;
        data_next.src       = in_data.src;
        data_next.dst       = in_data.dst;
        data_next.dinv_prod = {8'b0, da} * {8'b0, inv};
        data_next.sd_prod   = {8'b0, sa8} * {8'b0, da};
        if (in_data.sa >= 9'd255) begin
            data_next.kind = KIND_FULL;
        end else if (da == 8'd0) begin
            data_next.kind = (sa8 != 8'd0) ? KIND_SRC : KIND_ZERO;
        end else if (sa8 == 8'd0) begin
            data_next.kind = KIND_DST;
        end else begin
            data_next.kind = KIND_BLEND;
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- hw/rtl/abu_norm_stage.sv -----
// Stage 3: divide the alpha products by 255 and form the output alpha.
// Depends on abu_pkg.
module abu_norm_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  abu_pkg::weight_req_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output abu_pkg::norm_req_t   out_data
);
    import abu_pkg::*;

    // Exact floor(x / 255) for x up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

    logic       valid_reg, valid_next;
    norm_req_t  data_reg, data_next;
    logic [7:0] sd_q;
    logic [8:0] oa_sum;

    assign sd_q   = div255(in_data.sd_prod);
    assign oa_sum = {1'b0, in_data.sa8} + {1'b0, in_data.dst[31:24]} - {1'b0, sd_q};

    always_comb begin
        data_next.kind = in_data.kind;
        data_next.sa8  = in_data.sa8;
        data_next.src  = in_data.src;
        data_next.dst  = in_data.dst;
        data_next.dmul = div255(in_data.dinv_prod);
        data_next.oa   = oa_sum[7:0];
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- hw/rtl/abu_mix_stage.sv -----
// Stage 4: weight the colour channels and select the result pixel.
// Depends on abu_pkg.
module abu_mix_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  abu_pkg::norm_req_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       out_pixel
);
    import abu_pkg::*;

    localparam logic [31:0] ALPHA_MASK = 32'hff00_0000;
    localparam logic [31:0] RGB_MASK   = 32'h00ff_ffff;

    // Lane sum stays below 2^16 since sa + dmul never exceeds 255
    function automatic logic [7:0] mix8(input logic [7:0] cs, input logic [7:0] cd,
                                        input logic [7:0] ws, input logic [7:0] wd);
        logic [15:0] p;
        p = ({8'b0, cs} * {8'b0, ws}) + ({8'b0, cd} * {8'b0, wd});
        return p[15:8];
    endfunction

    logic        valid_reg, valid_next;
    logic [31:0] pixel_reg, pixel_next;
    logic [23:0] rgb;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            rgb[8*c +: 8] = mix8(in_data.src[8*c +: 8], in_data.dst[8*c +: 8],
                                 in_data.sa8, in_data.dmul);
        end
    end

    always_comb begin
        case (in_data.kind)
            KIND_FULL:  pixel_next = ALPHA_MASK | in_data.src;
            KIND_SRC:   pixel_next = {in_data.sa8, 24'h0} | (in_data.src & RGB_MASK);
            KIND_ZERO:  pixel_next = 32'h0;
            KIND_DST:   pixel_next = in_data.dst;
            KIND_BLEND: pixel_next = {in_data.oa, rgb};
            default:    pixel_next = in_data.dst;
        endcase
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            pixel_reg <= pixel_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pixel = pixel_reg;

endmodule

// ----- hw/rtl/argb_alpha_blend_unit.sv -----
// Top level of the ARGB8888 source-over alpha blend unit.
// Depends on abu_pkg, the four abu_*_stage modules and the assertion header.
//
// Blends one source pixel over one destination pixel per request and returns
// the composited pixel; no state is kept between requests. The source alpha is
// the pixel's own alpha (cmd 0, and the unused code 3), an explicit alpha
// (cmd 1) or the pixel alpha times a Q8 factor, truncated (cmd 2). A request
// is accepted every clock while m_ready stays high: the unit is a four-stage
// pipeline (alpha select, classify and alpha products, divide by 255, channel
// weighting) and each stage holds one request. The first stage is loaded at
// the accepting edge; the request then moves through the weight, norm and mix
// stage registers in turn, and m_valid rises once the mix stage holds it. The
// sustained rate is one pixel per cycle while m_ready stays high, set by each
// stage taking a new request in the same cycle as it hands its own on. When
// m_ready is held low the stages fill up in turn and s_ready drops only once
// all four hold a request. No clearing pass is needed after reset.
`include "argb_alpha_blend_unit_assert.svh"

module argb_alpha_blend_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [31:0] s_src_pixel,
    input  logic [31:0] s_dst_pixel,
    input  logic [7:0]  s_explicit_alpha,
    input  logic [8:0]  s_alpha_scale,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_out_pixel
);
    import abu_pkg::*;

    // Inter-stage requests
    logic        a_valid, a_ready;
    alpha_req_t  a_data;
    logic        w_valid, w_ready;
    weight_req_t w_data;
    logic        n_valid, n_ready;
    norm_req_t   n_data;

    // Select the effective source alpha
    abu_alpha_stage u_alpha (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_valid),
        .in_ready       (s_ready),
        .cmd            (s_cmd),
        .src_pixel      (s_src_pixel),
        .dst_pixel      (s_dst_pixel),
        .explicit_alpha (s_explicit_alpha),
        .alpha_scale    (s_alpha_scale),
        .out_valid      (a_valid),
        .out_ready      (a_ready),
        .out_data       (a_data)
    );

    // Classify the special cases and multiply the alphas
    abu_weight_stage u_weight (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (a_valid),
        .in_ready  (a_ready),
        .in_data   (a_data),
        .out_valid (w_valid),
        .out_ready (w_ready),
        .out_data  (w_data)
    );

    // Divide by 255: destination weight and combined alpha
    abu_norm_stage u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (w_valid),
        .in_ready  (w_ready),
        .in_data   (w_data),
        .out_valid (n_valid),
        .out_ready (n_ready),
        .out_data  (n_data)
    );

    // Weight R, G and B and hold the result for the consumer
    abu_mix_stage u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (n_valid),
        .in_ready  (n_ready),
        .in_data   (n_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_pixel (m_out_pixel)
    );

    // An accepted request always lands in the first stage
    `ABU_ASSERT_NEXT(a_accept_lands, s_valid && s_ready, a_valid, "accepted request lost")
    // Back-pressure reaches the input only when the output stalls
    `ABU_ASSERT_SAME(a_stall_source, !s_ready, m_valid && !m_ready, "input stalled without cause")
    // A blend only happens with both alphas non-zero
    `ABU_ASSERT_SAME(a_blend_alphas, w_valid && w_data.kind == KIND_BLEND,
        w_data.sa8 != 8'd0 && w_data.dst[31:24] != 8'd0, "blend with a zero alpha")
    // Channel weights must not overflow a lane
    `ABU_ASSERT_SAME(a_lane_weight, n_valid && n_data.kind == KIND_BLEND,
        ({1'b0, n_data.sa8} + {1'b0, n_data.dmul}) <= 9'd255, "lane weight overflow")
    // Combined alpha covers at least the source and the destination alpha
    `ABU_ASSERT_SAME(a_alpha_cover, n_valid && n_data.kind == KIND_BLEND,
        n_data.oa >= n_data.sa8 && n_data.oa >= n_data.dst[31:24], "combined alpha too small")

endmodule
